// File: design/cmdp_pkg.sv
// ----------------------------------------------------------------------------
// cmdp_pkg
// Shared types, codes and command text for the command line parser.
// ----------------------------------------------------------------------------
package cmdp_pkg;

  localparam int unsigned NUM_CMDS  = 7;
  localparam int unsigned CFG_IDX_W = 2;

  // Command slots, one candidate bit each
  localparam int unsigned CMD_OFF     = 0;
  localparam int unsigned CMD_SCALE_F = 1;
  localparam int unsigned CMD_SCALE_C = 2;
  localparam int unsigned CMD_STOP    = 3;
  localparam int unsigned CMD_START   = 4;
  localparam int unsigned CMD_LOG     = 5;
  localparam int unsigned CMD_PERIOD  = 6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SCALE  = 2'd1;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;

  typedef enum logic [3:0] {
    EV_NONE     = 4'd0,
    EV_OFF      = 4'd1,
    EV_SCALE_F  = 4'd2,
    EV_SCALE_C  = 4'd3,
    EV_STOP     = 4'd4,
    EV_START    = 4'd5,
    EV_LOG_CHAR = 4'd6,
    EV_LOG_END  = 4'd7,
    EV_PERIOD   = 4'd8,
    EV_BOGUS    = 4'd9
  } event_e;

  typedef struct packed {
    event_e     ev;
    logic [7:0] echo;
  } line_evt_t;

  typedef struct packed {
    logic shut;
    logic stopped;
    logic celsius;
  } status_t;

  function automatic logic [63:0] cmd_text(input logic [2:0] k);
    case (k)
      3'd0:    return 64'("OFF");
      3'd1:    return 64'("SCALE=F");
      3'd2:    return 64'("SCALE=C");
      3'd3:    return 64'("STOP");
      3'd4:    return 64'("START");
      3'd5:    return 64'("LOG ");
      3'd6:    return 64'("PERIOD=");
      default: return 64'd0;
    endcase
  endfunction

  function automatic logic [3:0] cmd_len(input logic [2:0] k);
    case (k)
      3'd0:    return 4'd3;
      3'd1:    return 4'd7;
      3'd2:    return 4'd7;
      3'd3:    return 4'd4;
      3'd4:    return 4'd5;
      3'd5:    return 4'd4;
      3'd6:    return 4'd7;
      default: return 4'd0;
    endcase
  endfunction

  // Character p of command k; only meaningful for p below the command length
  function automatic logic [7:0] cmd_char(input logic [2:0] k, input logic [3:0] p);
    logic [63:0] txt;
    logic [3:0]  rem;
    logic [5:0]  sh;
    txt = cmd_text(k);
    rem = cmd_len(k) - 4'd1 - p;
    sh  = {rem[2:0], 3'b000};
    return txt[sh +: 8];
  endfunction

endpackage

// File: design/text_command_line_parser_core.sv
// ----------------------------------------------------------------------------
// text_command_line_parser_core
// Byte-stream command line parser: matches commands per line, echoes LOG
// text, tracks period, scale, stop and shutdown.
//
//   channel  | dir | handshake               | payload
//   ---------+-----+-------------------------+-------------------------------
//   s_axis   | in  | s_axis_tvalid/tready    | in_byte
//   m_axis   | out | m_axis_tvalid/tready    | tuser event; tdata log char,
//            |     |                         | period, flags
//   cfg      | in  | cfg_valid/cfg_ready     | cfg_index, cfg_data
//
// One word per cycle while m_axis_tready_i is high; input register, then
// result register, with the single-pass decode between them.
// Reset clears line state, period to 1, scale to Fahrenheit, flags to 0.
// Output stall holds both registers; input still fills an empty input
// register. Config writes are taken every cycle (cfg_ready_o tied high).
// ----------------------------------------------------------------------------
module text_command_line_parser_core #(
  parameter int unsigned PERIOD_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [7:0]                     s_axis_tdata_i,  // [7:0] in_byte
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [7:0] log_char, [23:8] period_value, [24] scale_is_celsius,
  // [25] is_stopped, [31:26] zero
  output logic [31:0]                    m_axis_tdata_o,
  output logic [3:0]                     m_axis_tuser_o,  // [3:0] event_res
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cmdp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                    cfg_data_i
);
  import cmdp_pkg::*;

  logic                    in_valid_q;
  logic [7:0]              in_byte_q;
  logic                    out_valid_q;
  event_e                  ev_q;
  logic [7:0]              echo_q;
  logic [15:0]             period_q;
  logic                    celsius_q;
  logic                    stopped_q;
  logic                    adv;
  logic                    step;
  line_evt_t               evt;
  logic [PERIOD_WIDTH-1:0] acc;
  logic [PERIOD_WIDTH-1:0] period_d;
  logic [31:0]             period_ext;
  status_t                 stat_q, stat_d;

  assign adv             = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && adv;
  assign s_axis_tready_o = !in_valid_q || adv;
  assign cfg_ready_o     = 1'b1;
  assign period_ext      = 32'(period_d);

  cmdp_line #(
    .PERIOD_WIDTH (PERIOD_WIDTH)
  ) u_line (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .shut_i (stat_q.shut),
    .evt_o  (evt),
    .acc_o  (acc)
  );

  cmdp_settings #(
    .PERIOD_WIDTH (PERIOD_WIDTH)
  ) u_settings (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .ev_i       (evt.ev),
    .acc_i      (acc),
    .cfg_we_i   (cfg_valid_i),
    .cfg_idx_i  (cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .stat_q_o   (stat_q),
    .stat_d_o   (stat_d),
    .period_d_o (period_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (step) begin
      ev_q      <= evt.ev;
      echo_q    <= evt.echo;
      period_q  <= period_ext[15:0];
      celsius_q <= stat_d.celsius;
      stopped_q <= stat_d.stopped;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = ev_q;
  assign m_axis_tdata_o  = {6'b000000, stopped_q, celsius_q, period_q, echo_q};

`ifndef ASSERT_OFF
  a_quiet_after_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && stat_q.shut |=> ev_q == EV_NONE)
    else $error("event reported after shutdown");

  a_nul_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && (in_byte_q == CH_NUL) |=> ev_q == EV_NONE)
    else $error("zero byte produced an event");

  a_echo_only_log: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (ev_q == EV_LOG_CHAR) || (echo_q == 8'd0))
    else $error("log char set outside log echo");
`endif

endmodule

// File: design/cmdp_line.sv
// ----------------------------------------------------------------------------
// cmdp_line
// Per-line state: position, prefix candidates, period digits; decodes the
// event for each byte.
// ----------------------------------------------------------------------------
module cmdp_line #(
  parameter int unsigned PERIOD_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic [7:0]              byte_i,
  input  logic                    shut_i,
  output cmdp_pkg::line_evt_t     evt_o,
  output logic [PERIOD_WIDTH-1:0] acc_o
);
  import cmdp_pkg::*;

  localparam int unsigned AW = PERIOD_WIDTH + 4;

  logic [3:0]              pos_q, pos_d;
  logic [NUM_CMDS-1:0]     cand_q, cand_d, cand_t;
  logic                    rej_q, rej_d;
  logic                    digit_q, digit_d;
  logic [PERIOD_WIDTH-1:0] acc_q, acc_d, acc_sat;
  logic [AW-1:0]           acc_ext, prod;
  logic [3:0]              dig;
  logic                    is_digit;
  logic                    active;
  event_e                  fin_ev;

  assign active   = !shut_i && (byte_i != CH_NUL);
  assign is_digit = (byte_i >= CH_0) && (byte_i <= CH_9);
  assign dig      = 4'(byte_i - CH_0);
  assign acc_ext  = AW'(acc_q);
  assign prod     = (acc_ext << 3) + (acc_ext << 1) + AW'(dig);
  assign acc_sat  = (|prod[AW-1 -: 4]) ? '1 : prod[PERIOD_WIDTH-1:0];
  assign acc_o    = acc_q;

  always_comb begin
    fin_ev = EV_BOGUS;
    for (int k = 0; k < int'(CMD_LOG); k++) begin
      if (cand_q[k] && (pos_q == cmd_len(3'(k)))) begin
        fin_ev = event_e'(4'(k + 1));
      end
    end
    if (cand_q[CMD_LOG] && (pos_q >= cmd_len(3'(CMD_LOG)))) begin
      fin_ev = EV_LOG_END;
    end
    if (cand_q[CMD_PERIOD] && (pos_q > cmd_len(3'(CMD_PERIOD))) && digit_q && !rej_q) begin
      fin_ev = EV_PERIOD;
    end
  end

  always_comb begin
    cand_t = cand_q;
    for (int k = 0; k < int'(NUM_CMDS); k++) begin
      if (pos_q < cmd_len(3'(k))) begin
        if (cmd_char(3'(k), pos_q) != byte_i) begin
          cand_t[k] = 1'b0;
        end
      end else if (k < int'(CMD_LOG)) begin
        cand_t[k] = 1'b0;
      end
    end
  end

  always_comb begin
    evt_o.ev   = EV_NONE;
    evt_o.echo = 8'd0;
    pos_d      = pos_q;
    cand_d     = cand_q;
    rej_d      = rej_q;
    digit_d    = digit_q;
    acc_d      = acc_q;
    if (step_i && active) begin
      if (byte_i == CH_NL) begin
        evt_o.ev = fin_ev;
        pos_d    = 4'd0;
        cand_d   = '1;
        rej_d    = 1'b0;
        digit_d  = 1'b0;
        acc_d    = '0;
      end else begin
        if (cand_q[CMD_LOG] && (pos_q >= cmd_len(3'(CMD_LOG)))) begin
          evt_o.ev   = EV_LOG_CHAR;
          evt_o.echo = byte_i;
        end
        cand_d = cand_t;
        if (cand_t[CMD_PERIOD] && (pos_q >= cmd_len(3'(CMD_PERIOD)))) begin
          if (is_digit) begin
            acc_d   = acc_sat;
            digit_d = 1'b1;
          end else begin
            rej_d = 1'b1;
          end
        end
        if (pos_q != 4'hF) begin
          pos_d = pos_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 4'd0;
      cand_q  <= '1;
      rej_q   <= 1'b0;
      digit_q <= 1'b0;
      acc_q   <= '0;
    end else begin
      pos_q   <= pos_d;
      cand_q  <= cand_d;
      rej_q   <= rej_d;
      digit_q <= digit_d;
      acc_q   <= acc_d;
    end
  end

endmodule

// File: design/cmdp_settings.sv
// ----------------------------------------------------------------------------
// cmdp_settings
// Persistent settings: period, scale, stop and shutdown flags, with the
// configuration register writes.
// ----------------------------------------------------------------------------
module cmdp_settings #(
  parameter int unsigned PERIOD_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  cmdp_pkg::event_e                 ev_i,
  input  logic [PERIOD_WIDTH-1:0]          acc_i,
  input  logic                             cfg_we_i,
  input  logic [cmdp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [15:0]                      cfg_data_i,
  output cmdp_pkg::status_t                stat_q_o,
  output cmdp_pkg::status_t                stat_d_o,
  output logic [PERIOD_WIDTH-1:0]          period_d_o
);
  import cmdp_pkg::*;

  localparam logic [PERIOD_WIDTH-1:0] PERIOD_MAX = '1;

  status_t                 stat_q, stat_d;
  logic [PERIOD_WIDTH-1:0] period_q, period_d;
  logic [31:0]             cfg_ext;
  logic [PERIOD_WIDTH-1:0] cfg_period;

  assign cfg_ext    = 32'(cfg_data_i);
  assign cfg_period = (cfg_ext > 32'(PERIOD_MAX)) ? PERIOD_MAX : PERIOD_WIDTH'(cfg_ext);

  always_comb begin
    stat_d   = stat_q;
    period_d = period_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_PERIOD: period_d       = cfg_period;
        CFG_START_SCALE:  stat_d.celsius = cfg_data_i[0];
        default: ;
      endcase
    end else if (step_i) begin
      case (ev_i)
        EV_OFF:     stat_d.shut    = 1'b1;
        EV_SCALE_F: stat_d.celsius = 1'b0;
        EV_SCALE_C: stat_d.celsius = 1'b1;
        EV_STOP:    stat_d.stopped = 1'b1;
        EV_START:   stat_d.stopped = 1'b0;
        EV_PERIOD:  period_d       = acc_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_q   <= '0;
      period_q <= PERIOD_WIDTH'(1);
    end else begin
      stat_q   <= stat_d;
      period_q <= period_d;
    end
  end

  assign stat_q_o   = stat_q;
  assign stat_d_o   = stat_d;
  assign period_d_o = period_d;

endmodule
